// File: rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants for the bilinear Bayer demosaic block.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int BBD_MAX_WIDTH = 1024;   // default line store depth
    localparam int SAMPLE_W      = 8;
    localparam int FWIDTH_W      = 11;     // frame_width register
    localparam int FHEIGHT_W     = 12;     // frame_height register
    localparam int ROW_W         = 12;
    localparam int CFG_DATA_W    = 12;

    localparam logic [FWIDTH_W-1:0]  FWIDTH_RESET  = FWIDTH_W'(320);
    localparam logic [FHEIGHT_W-1:0] FHEIGHT_RESET = FHEIGHT_W'(200);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Per-pixel control carried from the counter stage to interpolation
    typedef struct packed {
        logic emit;     // interior pixel, produce a result
        logic last;     // last interior pixel of the frame
        logic x_odd;    // interior column parity
        logic y_odd;    // interior row parity
    } pix_info_t;

endpackage

// File: rtl/bbd_line_buf.sv
// ----------------------------------------------------------------------------
// bbd_line_buf
// Two line stores (one and two rows up) with registered reads and a
// bypass for a write and read of the same column in one cycle.
// ----------------------------------------------------------------------------
module bbd_line_buf
    import bbd_pkg::*;
#(
    parameter int DEPTH = BBD_MAX_WIDTH,
    parameter int AW    = $clog2(BBD_MAX_WIDTH)
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  sample_t       wr_sample,
    output sample_t       top_sample,
    output sample_t       mid_sample
);

    sample_t near_mem [DEPTH];
    sample_t far_mem  [DEPTH];
    sample_t top_reg;
    sample_t mid_reg;

    // Write-back of the column just read: near value moves to far store.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            near_mem[wr_addr] <= wr_sample;
            far_mem[wr_addr]  <= mid_reg;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                top_reg <= mid_reg;
                mid_reg <= wr_sample;
            end
            else
            begin
                top_reg <= far_mem[rd_addr];
                mid_reg <= near_mem[rd_addr];
            end
        end
    end

    assign top_sample = top_reg;
    assign mid_sample = mid_reg;

endmodule

// File: rtl/bbd_interp.sv
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear color reconstruction from a 3x3 raw window.
// ----------------------------------------------------------------------------
module bbd_interp
    import bbd_pkg::*;
(
    input  sample_t   win [9],    // row-major, index 4 is the center
    input  pix_info_t info,
    output sample_t   red,
    output sample_t   green,
    output sample_t   blue
);

    logic [8:0] hor_sum;
    logic [8:0] ver_sum;
    logic [9:0] crs_sum;
    logic [9:0] dia_sum;
    sample_t    ctr;
    sample_t    hor;
    sample_t    ver;
    sample_t    crs;
    sample_t    dia;

    always_comb
    begin
        hor_sum = {1'b0, win[3]} + {1'b0, win[5]};
        ver_sum = {1'b0, win[1]} + {1'b0, win[7]};
        crs_sum = {1'b0, hor_sum} + {1'b0, ver_sum};
        dia_sum = ({2'b00, win[0]} + {2'b00, win[2]}) + ({2'b00, win[6]} + {2'b00, win[8]});
        ctr = win[4];
        hor = hor_sum[8:1];
        ver = ver_sum[8:1];
        crs = crs_sum[9:2];
        dia = dia_sum[9:2];

        unique case ({info.y_odd, info.x_odd})
            2'b11:
            begin
                red = ctr; green = crs; blue = dia;
            end
            2'b10:
            begin
                red = hor; green = ctr; blue = ver;
            end
            2'b01:
            begin
                red = ver; green = ctr; blue = hor;
            end
            default:
            begin
                red = dia; green = crs; blue = ctr;
            end
        endcase
    end

endmodule

// File: rtl/bayer_bilinear_demosaic.sv
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Streaming bilinear demosaic of raw 8-bit Bayer pixels, 3x3 window.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one raw sample per request in raster order; s_tuser set on
//   the first sample of a frame restarts the column and row counters.
//   m_* channel: one RGB request per interior pixel (border rows and columns
//   give nothing); m_tlast marks the last interior pixel of the frame.
//   cfg_*: frame_width / frame_height, written only while the block is idle.
// Throughput: one sample per cycle unless m_tready is low; the line stores
//   are read once and written once per sample, each on its own port.
// Pipeline: an accepted sample is loaded into the sample register while the
//   line stores are read, and its result enters the output register when the
//   middle stage advances.
// Reset: counters and window clear, registers go to 320 x 200; the line
//   stores are not cleared, the first two rows of a frame overwrite them.
// Stall: when m_tready is low, the held result stays put, the middle stage
//   keeps one more sample, and s_tready falls only once both are full.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = BBD_MAX_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // raw sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] raw_sample
    input  logic                  s_tuser,    // [0] frame_start
    // color stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    output logic                  m_tlast,    // frame_end
    // configuration
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);                    // column counter / address
    localparam int EW = ((CW > FWIDTH_W) ? CW : FWIDTH_W) + 1; // width compare

    // ---------------- configuration registers ----------------
    logic [FWIDTH_W-1:0]  fwidth_reg;
    logic [FHEIGHT_W-1:0] fheight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwidth_reg  <= FWIDTH_RESET;
            fheight_reg <= FHEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:  fwidth_reg  <= cfg_wdata[FWIDTH_W-1:0];
                REG_FRAME_HEIGHT: fheight_reg <= cfg_wdata[FHEIGHT_W-1:0];
                default:          fwidth_reg  <= fwidth_reg;
            endcase
        end
    end

    // Last column / row index, with the width clamped to [3, MAX_WIDTH]
    // and the height held at 3 minimum.
    logic [EW-1:0]    fw_ext;
    logic [CW-1:0]    col_last;
    logic [ROW_W-1:0] row_last;

    always_comb
    begin
        fw_ext = EW'(fwidth_reg);
        if (fw_ext < EW'(3))
            col_last = CW'(2);
        else if (fw_ext > EW'(MAX_WIDTH))
            col_last = CW'(MAX_WIDTH - 1);
        else
            col_last = CW'(fw_ext - EW'(1));

        if (fheight_reg < FHEIGHT_W'(3))
            row_last = ROW_W'(2);
        else
            row_last = ROW_W'(fheight_reg - FHEIGHT_W'(1));
    end

    // ---------------- handshake ----------------
    logic      s_accept;
    logic      b_valid_reg;
    logic      b_adv;
    logic      out_valid_reg;

    assign b_adv    = b_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !b_valid_reg || b_adv;
    assign s_accept = s_tvalid && s_tready;

    // ---------------- position counters ----------------
    logic [CW-1:0]    col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    pix_info_t        info_cur;

    always_comb
    begin
        col_cur = s_tuser ? '0 : col_reg;
        row_cur = s_tuser ? '0 : row_reg;

        if (col_cur >= col_last)
        begin
            col_next = '0;
            row_next = (row_cur >= row_last) ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + CW'(1);
            row_next = row_cur;
        end

        // the sample completes the window centered one up, one left
        info_cur.emit  = (col_cur >= CW'(2)) && (col_cur <= col_last) &&
                         (row_cur >= ROW_W'(2)) && (row_cur <= row_last);
        info_cur.last  = (col_cur == col_last) && (row_cur == row_last);
        info_cur.x_odd = ~col_cur[0];
        info_cur.y_odd = ~row_cur[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- middle stage: waits for line store read ----------------
    sample_t       b_sample_reg;
    logic [CW-1:0] b_addr_reg;
    pix_info_t     b_info_reg;
    logic          b_valid_next;

    assign b_valid_next = s_accept ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= b_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            b_sample_reg <= s_tdata;
            b_addr_reg   <= col_cur;
            b_info_reg   <= info_cur;
        end
    end

    sample_t top_sample;
    sample_t mid_sample;

    bbd_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk        (clk),
        .rd_en      (s_accept),
        .rd_addr    (col_cur),
        .wr_en      (b_adv),
        .wr_addr    (b_addr_reg),
        .wr_sample  (b_sample_reg),
        .top_sample (top_sample),
        .mid_sample (mid_sample)
    );

    // ---------------- 3x3 window ----------------
    // Columns shift left; the new column is far row, near row, new sample.
    sample_t win_reg  [9];
    sample_t win_next [9];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3 + 0] = win_reg[k*3 + 1];
            win_next[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_next[2] = top_sample;
        win_next[5] = mid_sample;
        win_next[8] = b_sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (b_adv)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= win_next[k];
        end
    end

    // ---------------- interpolation and output register ----------------
    sample_t red_c, green_c, blue_c;

    bbd_interp u_interp (
        .win   (win_next),
        .info  (b_info_reg),
        .red   (red_c),
        .green (green_c),
        .blue  (blue_c)
    );

    logic        out_valid_next;
    logic [23:0] out_data_reg;
    logic        out_last_reg;

    assign out_valid_next = (b_adv && b_info_reg.emit) ? 1'b1 :
                            (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && b_info_reg.emit)
        begin
            out_data_reg <= {blue_c, green_c, red_c};
            out_last_reg <= b_info_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/bbd_checker.sv
// ----------------------------------------------------------------------------
// bbd_checker
// Port-level checks for the demosaic block, bound to the top level.
// ----------------------------------------------------------------------------
module bbd_checker
    import bbd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // with the output register empty, input is never refused
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input refused with empty output");

    // a result taken frees the pipeline for a new sample
    a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |-> s_tready)
        else $error("input refused while output drains");

    // no result shown during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
